FILE: design/tfte_pkg.sv
`default_nettype none
package tfte_pkg;

   localparam int STORE_DEPTH        = 4096;
   localparam int STORE_AW           = $clog2(STORE_DEPTH);
   localparam int MAX_COMMAND_BYTES  = 4096;
   localparam int MAX_RESPONSE_BYTES = 4096;
   localparam int HEADER_BYTES       = 10;
   localparam int RSP_SLOTS          = 3;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_TICK  = 2'd3;

   localparam logic [1:0] CSR_ENABLED       = 2'd0;
   localparam logic [1:0] CSR_SHORT_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_LONG_TIMEOUT  = 2'd2;

   localparam logic [11:0] REG_ACCESS = 12'h000;
   localparam logic [11:0] REG_STS    = 12'h018;
   localparam logic [11:0] REG_FIFO   = 12'h024;

   localparam logic [7:0] ACC_REQUEST = 8'h02;
   localparam logic [7:0] ACC_HELD    = 8'hA0;
   localparam logic [7:0] STS_GO      = 8'h20;
   localparam logic [7:0] STS_READY   = 8'h40;
   localparam logic [7:0] STS_VALID   = 8'h80;
   localparam logic [7:0] STS_EXPECT  = 8'h08;
   localparam logic [7:0] STS_AVAIL   = 8'h10;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD_STATE = 4'd1;
   localparam logic [3:0] ST_BAD_ARG   = 4'd2;
   localparam logic [3:0] ST_TOO_SMALL = 4'd3;
   localparam logic [3:0] ST_BUSY      = 4'd4;
   localparam logic [3:0] ST_NOT_READY = 4'd5;
   localparam logic [3:0] ST_IO        = 4'd6;
   localparam logic [3:0] ST_TIMEOUT   = 4'd7;
   localparam logic [3:0] ST_CORRUPT   = 4'd8;
   localparam logic [3:0] ST_TRUNCATED = 4'd9;

   typedef struct packed {
      logic        bus_request;
      logic        bus_write;
      logic [11:0] bus_offset;
      logic        bus_dword;
      logic [7:0]  bus_wdata;
      logic        resp_valid;
      logic [7:0]  resp_byte;
      logic        done_res;
      logic [3:0]  status;
      logic [12:0] resp_length;
      logic        last;
   } rsp_type;

   function automatic rsp_type f_bus_rd(logic [11:0] off, logic dw);
      rsp_type r;
      r = '0;
      r.bus_request = 1'b1;
      r.bus_offset = off;
      r.bus_dword = dw;
      return r;
   endfunction

   function automatic rsp_type f_bus_wr(logic [11:0] off, logic [7:0] val);
      rsp_type r;
      r = '0;
      r.bus_request = 1'b1;
      r.bus_write = 1'b1;
      r.bus_offset = off;
      r.bus_wdata = val;
      return r;
   endfunction

   function automatic rsp_type f_byte(logic [7:0] b);
      rsp_type r;
      r = '0;
      r.resp_valid = 1'b1;
      r.resp_byte = b;
      return r;
   endfunction

   function automatic rsp_type f_done(logic [3:0] st, logic [12:0] len);
      rsp_type r;
      r = '0;
      r.done_res = 1'b1;
      r.status = st;
      r.resp_length = len;
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/tfte_store.sv
`default_nettype none
module tfte_store (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [tfte_pkg::STORE_AW-1:0] wr_addr,
   input  wire logic [7:0]                    wr_data,
   input  wire logic [tfte_pkg::STORE_AW-1:0] rd_addr,
   output logic      [7:0]                    rd_data
);

   logic [7:0] mem_ff [tfte_pkg::STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // write in the same cycle to the fetched address is forwarded
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/tfte_engine.sv
`default_nettype none
module tfte_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [1:0]                    cmd,
   input  wire logic [15:0]                   command_length,
   input  wire logic [15:0]                   response_capacity,
   input  wire logic [31:0]                   read_data,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [31:0]                   csr_wdata,
   input  wire logic [7:0]                    store_data,
   output logic      [tfte_pkg::STORE_AW-1:0] store_addr,
   output tfte_pkg::rsp_type                  res [tfte_pkg::RSP_SLOTS],
   output logic      [1:0]                    res_cnt
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_LOC_CHECK, PH_LOC_WAIT, PH_RDY_CHECK, PH_RDY_WAIT, PH_BURST,
      PH_WRITE, PH_EXP1_WAIT, PH_EXP1_CHECK, PH_EXP2_WAIT, PH_EXP2_CHECK,
      PH_RESP_WAIT, PH_RBURST, PH_RDATA
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        enabled_ff;
   logic [31:0] short_timeout_ff, long_timeout_ff;
   logic        ready_attempt_ff, ready_attempt_in;
   logic [12:0] bytes_done_ff, bytes_done_in;
   logic [15:0] burst_left_ff, burst_left_in;
   logic [31:0] wait_ticks_ff, wait_ticks_in;
   logic [31:0] claimed_size_ff, claimed_size_in;
   logic [12:0] total_length_ff, total_length_in;
   logic [15:0] capacity_held_ff, capacity_held_in;

   tfte_pkg::rsp_type r_v [tfte_pkg::RSP_SLOTS];
   logic [1:0]  n_v;
   logic [7:0]  flags;
   logic [15:0] burst;
   logic        short_out, long_out;
   logic        do_emit;
   logic [12:0] bd_v;
   logic [15:0] bl_v;
   logic [31:0] rem_v;
   logic [31:0] cs_v;

   assign flags = read_data[7:0];
   assign burst = read_data[23:8];
   assign short_out = wait_ticks_ff > short_timeout_ff;
   assign long_out = wait_ticks_ff > long_timeout_ff;

   always_comb begin
      phase_in = phase_ff;
      ready_attempt_in = ready_attempt_ff;
      bytes_done_in = bytes_done_ff;
      burst_left_in = burst_left_ff;
      wait_ticks_in = wait_ticks_ff;
      claimed_size_in = claimed_size_ff;
      total_length_in = total_length_ff;
      capacity_held_in = capacity_held_ff;
      n_v = 2'd0;
      for (int i = 0; i < tfte_pkg::RSP_SLOTS; i++) begin
         r_v[i] = '0;
      end
      do_emit = 1'b0;
      bd_v = '0;
      bl_v = '0;
      rem_v = '0;
      cs_v = '0;
      if (accept) begin
         case (cmd)
            tfte_pkg::CMD_START: begin
               if (phase_ff == PH_IDLE) begin
                  if (!enabled_ff) begin
                     r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_BAD_STATE, 13'd0);
                     n_v = n_v + 2'd1;
                  end else if ((32'(command_length) < 32'(tfte_pkg::HEADER_BYTES)) ||
                               (32'(command_length) > 32'(tfte_pkg::MAX_COMMAND_BYTES))) begin
                     r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_BAD_ARG, 13'd0);
                     n_v = n_v + 2'd1;
                  end else if (32'(response_capacity) < 32'(tfte_pkg::HEADER_BYTES)) begin
                     r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_TOO_SMALL, 13'd0);
                     n_v = n_v + 2'd1;
                  end else begin
                     total_length_in = command_length[12:0];
                     capacity_held_in = response_capacity;
                     ready_attempt_in = 1'b0;
                     bytes_done_in = '0;
                     burst_left_in = '0;
                     claimed_size_in = '0;
                     wait_ticks_in = '0;
                     phase_in = PH_LOC_CHECK;
                     r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_ACCESS, 1'b0);
                     n_v = n_v + 2'd1;
                  end
               end
            end
            tfte_pkg::CMD_READ: begin
               case (phase_ff)
                  PH_LOC_CHECK, PH_LOC_WAIT: begin
                     if ((flags & tfte_pkg::ACC_HELD) == tfte_pkg::ACC_HELD) begin
                        phase_in = PH_RDY_CHECK;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end else if (phase_ff == PH_LOC_CHECK) begin
                        r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_ACCESS,
                                                      tfte_pkg::ACC_REQUEST);
                        n_v = n_v + 2'd1;
                        wait_ticks_in = '0;
                        phase_in = PH_LOC_WAIT;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_ACCESS, 1'b0);
                        n_v = n_v + 2'd1;
                     end else if (short_out) begin
                        phase_in = PH_IDLE;
                        r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_BUSY, 13'd0);
                        n_v = n_v + 2'd1;
                     end else begin
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_ACCESS, 1'b0);
                        n_v = n_v + 2'd1;
                     end
                  end
                  PH_RDY_CHECK, PH_RDY_WAIT: begin
                     if ((flags & tfte_pkg::STS_READY) != 8'd0) begin
                        bytes_done_in = '0;
                        wait_ticks_in = '0;
                        phase_in = PH_BURST;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end else if (phase_ff == PH_RDY_CHECK) begin
                        r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS, tfte_pkg::STS_READY);
                        n_v = n_v + 2'd1;
                        wait_ticks_in = '0;
                        phase_in = PH_RDY_WAIT;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end else if (short_out) begin
                        if (!ready_attempt_ff) begin
                           ready_attempt_in = 1'b1;
                           phase_in = PH_RDY_CHECK;
                           r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                           n_v = n_v + 2'd1;
                        end else begin
                           r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS,
                                                         tfte_pkg::STS_READY);
                           n_v = n_v + 2'd1;
                           phase_in = PH_IDLE;
                           r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_NOT_READY, 13'd0);
                           n_v = n_v + 2'd1;
                        end
                     end else begin
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end
                  end
                  PH_BURST: begin
                     if (burst != 16'd0) begin
                        rem_v = 32'(total_length_ff - 13'd1 - bytes_done_ff);
                        burst_left_in = (32'(burst) < rem_v) ? burst : rem_v[15:0];
                        do_emit = 1'b1;
                     end else if (short_out) begin
                        r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS, tfte_pkg::STS_READY);
                        n_v = n_v + 2'd1;
                        phase_in = PH_IDLE;
                        r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_IO, 13'd0);
                        n_v = n_v + 2'd1;
                     end else begin
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end
                  end
                  PH_EXP1_WAIT, PH_EXP2_WAIT: begin
                     if ((flags & tfte_pkg::STS_VALID) != 8'd0) begin
                        phase_in = (phase_ff == PH_EXP1_WAIT) ? PH_EXP1_CHECK : PH_EXP2_CHECK;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end else if (short_out) begin
                        r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS, tfte_pkg::STS_READY);
                        n_v = n_v + 2'd1;
                        phase_in = PH_IDLE;
                        r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_TIMEOUT, 13'd0);
                        n_v = n_v + 2'd1;
                     end else begin
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end
                  end
                  PH_EXP1_CHECK, PH_EXP2_CHECK: begin
                     if (((phase_ff == PH_EXP1_CHECK) &&
                          ((flags & tfte_pkg::STS_EXPECT) == 8'd0)) ||
                         ((phase_ff == PH_EXP2_CHECK) &&
                          ((flags & tfte_pkg::STS_EXPECT) != 8'd0))) begin
                        r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS, tfte_pkg::STS_READY);
                        n_v = n_v + 2'd1;
                        phase_in = PH_IDLE;
                        r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_IO, 13'd0);
                        n_v = n_v + 2'd1;
                     end else begin
                        if (phase_ff == PH_EXP1_CHECK) begin
                           // last command byte, bytes_done sits at length - 1
                           r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_FIFO, store_data);
                           phase_in = PH_EXP2_WAIT;
                        end else begin
                           r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS, tfte_pkg::STS_GO);
                           phase_in = PH_RESP_WAIT;
                        end
                        n_v = n_v + 2'd1;
                        wait_ticks_in = '0;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end
                  end
                  PH_RESP_WAIT: begin
                     if ((flags & (tfte_pkg::STS_VALID | tfte_pkg::STS_AVAIL)) ==
                         (tfte_pkg::STS_VALID | tfte_pkg::STS_AVAIL)) begin
                        bytes_done_in = '0;
                        claimed_size_in = '0;
                        wait_ticks_in = '0;
                        phase_in = PH_RBURST;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end else if (long_out) begin
                        r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS, tfte_pkg::STS_READY);
                        n_v = n_v + 2'd1;
                        phase_in = PH_IDLE;
                        r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_TIMEOUT, 13'd0);
                        n_v = n_v + 2'd1;
                     end else begin
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end
                  end
                  PH_RBURST: begin
                     if (burst != 16'd0) begin
                        rem_v = ((32'(bytes_done_ff) < 32'(tfte_pkg::HEADER_BYTES)) ?
                                 32'(tfte_pkg::HEADER_BYTES) : claimed_size_ff) -
                                32'(bytes_done_ff);
                        burst_left_in = (32'(burst) < rem_v) ? burst : rem_v[15:0];
                        phase_in = PH_RDATA;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_FIFO, 1'b0);
                        n_v = n_v + 2'd1;
                     end else if (short_out) begin
                        r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS, tfte_pkg::STS_READY);
                        n_v = n_v + 2'd1;
                        phase_in = PH_IDLE;
                        r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_IO, 13'd0);
                        n_v = n_v + 2'd1;
                     end else begin
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end
                  end
                  PH_RDATA: begin
                     r_v[n_v] = tfte_pkg::f_byte(flags);
                     n_v = n_v + 2'd1;
                     cs_v = claimed_size_ff;
                     if ((bytes_done_ff >= 13'd2) && (bytes_done_ff <= 13'd5)) begin
                        cs_v = {claimed_size_ff[23:0], flags};
                     end
                     claimed_size_in = cs_v;
                     bd_v = bytes_done_ff + 13'd1;
                     bytes_done_in = bd_v;
                     bl_v = (burst_left_ff != 16'd0) ? (burst_left_ff - 16'd1) : burst_left_ff;
                     burst_left_in = bl_v;
                     if (32'(bd_v) == 32'(tfte_pkg::HEADER_BYTES)) begin
                        if ((cs_v < 32'(tfte_pkg::HEADER_BYTES)) ||
                            (cs_v > 32'(tfte_pkg::MAX_RESPONSE_BYTES))) begin
                           r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS,
                                                         tfte_pkg::STS_READY);
                           n_v = n_v + 2'd1;
                           phase_in = PH_IDLE;
                           r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_CORRUPT, 13'd0);
                           n_v = n_v + 2'd1;
                        end else if (cs_v > 32'(capacity_held_ff)) begin
                           r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS,
                                                         tfte_pkg::STS_READY);
                           n_v = n_v + 2'd1;
                           phase_in = PH_IDLE;
                           r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_TRUNCATED, 13'd0);
                           n_v = n_v + 2'd1;
                        end else if (cs_v == 32'(tfte_pkg::HEADER_BYTES)) begin
                           r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS,
                                                         tfte_pkg::STS_READY);
                           n_v = n_v + 2'd1;
                           phase_in = PH_IDLE;
                           r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_OK, cs_v[12:0]);
                           n_v = n_v + 2'd1;
                        end else begin
                           wait_ticks_in = '0;
                           phase_in = PH_RBURST;
                           r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                           n_v = n_v + 2'd1;
                        end
                     end else if ((32'(bd_v) > 32'(tfte_pkg::HEADER_BYTES)) &&
                                  (32'(bd_v) >= cs_v)) begin
                        r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_STS, tfte_pkg::STS_READY);
                        n_v = n_v + 2'd1;
                        phase_in = PH_IDLE;
                        r_v[n_v] = tfte_pkg::f_done(tfte_pkg::ST_OK, cs_v[12:0]);
                        n_v = n_v + 2'd1;
                     end else if (bl_v == 16'd0) begin
                        wait_ticks_in = '0;
                        phase_in = PH_RBURST;
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
                        n_v = n_v + 2'd1;
                     end else begin
                        r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_FIFO, 1'b0);
                        n_v = n_v + 2'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            tfte_pkg::CMD_TICK: begin
               if (phase_ff == PH_WRITE) begin
                  do_emit = 1'b1;
               end else if ((phase_ff != PH_IDLE) && (wait_ticks_ff != 32'hFFFF_FFFF)) begin
                  wait_ticks_in = wait_ticks_ff + 32'd1;
               end
            end
            default: begin
            end
         endcase

         // one command byte to the fifo
         if (do_emit) begin
            r_v[n_v] = tfte_pkg::f_bus_wr(tfte_pkg::REG_FIFO, store_data);
            n_v = n_v + 2'd1;
            bd_v = bytes_done_ff + 13'd1;
            bytes_done_in = bd_v;
            bl_v = (burst_left_in != 16'd0) ? (burst_left_in - 16'd1) : burst_left_in;
            burst_left_in = bl_v;
            phase_in = PH_WRITE;
            if (bl_v == 16'd0) begin
               wait_ticks_in = '0;
               phase_in = ((bd_v + 13'd1) < total_length_ff) ? PH_BURST : PH_EXP1_WAIT;
               r_v[n_v] = tfte_pkg::f_bus_rd(tfte_pkg::REG_STS, 1'b1);
               n_v = n_v + 2'd1;
            end
         end
      end
      if (n_v != 2'd0) begin
         r_v[n_v - 2'd1].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         enabled_ff <= 1'b0;
         short_timeout_ff <= 32'd1000000;
         long_timeout_ff <= 32'd5000000;
         ready_attempt_ff <= 1'b0;
         bytes_done_ff <= '0;
         burst_left_ff <= '0;
         wait_ticks_ff <= '0;
         claimed_size_ff <= '0;
         total_length_ff <= '0;
         capacity_held_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         ready_attempt_ff <= ready_attempt_in;
         bytes_done_ff <= bytes_done_in;
         burst_left_ff <= burst_left_in;
         wait_ticks_ff <= wait_ticks_in;
         claimed_size_ff <= claimed_size_in;
         total_length_ff <= total_length_in;
         capacity_held_ff <= capacity_held_in;
         if (csr_we) begin
            case (csr_index)
               tfte_pkg::CSR_ENABLED:       enabled_ff <= csr_wdata[0];
               tfte_pkg::CSR_SHORT_TIMEOUT: short_timeout_ff <= csr_wdata;
               tfte_pkg::CSR_LONG_TIMEOUT:  long_timeout_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // fetch the byte at the next write position
   assign store_addr = bytes_done_in[tfte_pkg::STORE_AW-1:0];
   assign res = r_v;
   assign res_cnt = n_v;

endmodule
`default_nettype wire

FILE: design/tfte_rsp_buf.sv
`default_nettype none
module tfte_rsp_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic [1:0]        load_cnt,
   input  tfte_pkg::rsp_type      load_data [tfte_pkg::RSP_SLOTS],
   input  wire logic              out_stall,
   output logic                   out_valid,
   output tfte_pkg::rsp_type      out_data,
   output logic                   in_ready
);

   tfte_pkg::rsp_type slot_ff [tfte_pkg::RSP_SLOTS];
   logic [1:0] cnt_ff;
   logic       pop;

   assign out_valid = cnt_ff != 2'd0;
   assign pop = out_valid && !out_stall;
   assign in_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !out_stall);
   assign out_data = slot_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= load_cnt;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= load_data;
      end else if (pop) begin
         for (int i = 0; i < tfte_pkg::RSP_SLOTS - 1; i++) begin
            slot_ff[i] <= slot_ff[i + 1];
         end
      end
   end

endmodule
`default_nettype wire

FILE: design/tpm_fifo_transaction_engine.sv
`default_nettype none
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  cmd, index, byte, length, capacity, read data
// rsp       out        rsp_valid / rsp_stall  one bus access, response byte or completion
// csr       in         csr_we                 csr_index, csr_wdata
// a request is handled in the cycle it is accepted and gives zero to three responses
// responses sit in a three-entry buffer; a request is taken when the buffer is empty or its last entry leaves
// one request per cycle when each gives at most one response and rsp is not stalled
// the command store is one write port and one registered read port, prefetched
// reset is synchronous; the command store is not cleared
module tpm_fifo_transaction_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [11:0] req_byte_index,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [15:0] req_command_length,
   input  wire logic [15:0] req_response_capacity,
   input  wire logic [31:0] req_read_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_bus_request,
   output logic             rsp_bus_write,
   output logic      [11:0] rsp_bus_offset,
   output logic             rsp_bus_dword,
   output logic      [7:0]  rsp_bus_wdata,
   output logic             rsp_resp_valid,
   output logic      [7:0]  rsp_resp_byte,
   output logic             rsp_done_res,
   output logic      [3:0]  rsp_status,
   output logic      [12:0] rsp_resp_length,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic                          accept;
   logic                          in_ready;
   logic [7:0]                    store_data;
   logic [tfte_pkg::STORE_AW-1:0] store_addr;
   tfte_pkg::rsp_type             res [tfte_pkg::RSP_SLOTS];
   logic [1:0]                    res_cnt;
   tfte_pkg::rsp_type             out_data;

   assign req_stall = !in_ready;
   assign accept = req_valid && in_ready;

   tfte_store u_store (
      .clock   (clock),
      .wr_en   (accept && (req_cmd == tfte_pkg::CMD_LOAD)),
      .wr_addr (req_byte_index),
      .wr_data (req_data_byte),
      .rd_addr (store_addr),
      .rd_data (store_data)
   );

   tfte_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .cmd               (req_cmd),
      .command_length    (req_command_length),
      .response_capacity (req_response_capacity),
      .read_data         (req_read_data),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .store_data        (store_data),
      .store_addr        (store_addr),
      .res               (res),
      .res_cnt           (res_cnt)
   );

   tfte_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && (res_cnt != 2'd0)),
      .load_cnt  (res_cnt),
      .load_data (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .in_ready  (in_ready)
   );

   assign rsp_bus_request = out_data.bus_request;
   assign rsp_bus_write = out_data.bus_write;
   assign rsp_bus_offset = out_data.bus_offset;
   assign rsp_bus_dword = out_data.bus_dword;
   assign rsp_bus_wdata = out_data.bus_wdata;
   assign rsp_resp_valid = out_data.resp_valid;
   assign rsp_resp_byte = out_data.resp_byte;
   assign rsp_done_res = out_data.done_res;
   assign rsp_status = out_data.status;
   assign rsp_resp_length = out_data.resp_length;
   assign rsp_last = out_data.last;

endmodule
`default_nettype wire
